### hw/rtl/brl_pkg.sv
// shared types and constants for the line rasterizer
package brl_pkg;

    localparam int COORD_BITS   = 12;
    localparam int COLOR_BITS   = 24;
    localparam int DEC_BITS     = COORD_BITS + 2;
    localparam int S_TDATA_BITS = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } opcode_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DEC_BITS-1:0]   dec_t;

    typedef struct packed {
        opcode_t               kind;
        logic                  major_is_x;
        logic                  minor_down;
        logic                  single;
        coord_t                start_x;
        coord_t                start_y;
        coord_t                end_major;
        dec_t                  decision;
        dec_t                  inc_straight;
        dec_t                  inc_diagonal;
        logic [COLOR_BITS-1:0] color;
    } cmd_t;

endpackage

### hw/rtl/brl_front.sv
// request decode and line setup: axis choice, endpoint order, decision terms
module brl_front import brl_pkg::*; (
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    input  logic                    s_tuser,
    input  logic                    q_full,
    output logic                    q_push,
    output cmd_t                    q_cmd
);

    coord_t                  xa, ya, xb, yb;
    coord_t                  sx, sy, ex, ey;
    logic signed [COORD_BITS:0] dx, dy, adx, ady, maj, mnr;
    logic                    major_x, swap;
    dec_t                    two_mnr;

    assign xa = coord_t'(s_tdata[COORD_BITS-1:0]);
    assign ya = coord_t'(s_tdata[2*COORD_BITS-1:COORD_BITS]);
    assign xb = coord_t'(s_tdata[3*COORD_BITS-1:2*COORD_BITS]);
    assign yb = coord_t'(s_tdata[4*COORD_BITS-1:3*COORD_BITS]);

    always_comb begin
        dx      = {xb[COORD_BITS-1], xb} - {xa[COORD_BITS-1], xa};
        dy      = {yb[COORD_BITS-1], yb} - {ya[COORD_BITS-1], ya};
        adx     = dx[COORD_BITS] ? -dx : dx;
        ady     = dy[COORD_BITS] ? -dy : dy;
        major_x = adx > ady;
        swap    = major_x ? (xa > xb) : (ya > yb);
        sx      = swap ? xb : xa;
        sy      = swap ? yb : ya;
        ex      = swap ? xa : xb;
        ey      = swap ? ya : yb;
        maj     = major_x ? adx : ady;
        mnr     = major_x ? ady : adx;
        two_mnr = dec_t'({mnr, 1'b0});

        q_cmd.kind         = opcode_t'(s_tuser);
        q_cmd.major_is_x   = major_x;
        q_cmd.minor_down   = major_x ? !(sy < ey) : !(sx < ex);
        q_cmd.single       = (maj == '0);
        q_cmd.start_x      = sx;
        q_cmd.start_y      = sy;
        q_cmd.end_major    = major_x ? ex : ey;
        q_cmd.inc_straight = two_mnr;
        q_cmd.inc_diagonal = two_mnr - dec_t'({maj, 1'b0});
        q_cmd.decision     = two_mnr - dec_t'(maj);
        q_cmd.color        = s_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

### hw/rtl/brl_cmd_queue.sv
// two-entry command queue between setup and stepper
module brl_cmd_queue import brl_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t       head_reg, head_next;
    cmd_t       tail_reg, tail_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = head_reg;
    assign do_pop     = pop && head_valid;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push && !do_pop) begin
            if (count_reg == 2'd0) begin
                head_next = push_cmd;
            end else begin
                tail_next = push_cmd;
            end
            count_next = count_reg + 2'd1;
        end else if (do_pop && !push) begin
            head_next  = tail_reg;
            count_next = count_reg - 2'd1;
        end else if (do_pop && push) begin
            if (count_reg == 2'd1) begin
                head_next = push_cmd;
            end else begin
                head_next = tail_reg;
                tail_next = push_cmd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

### hw/rtl/brl_stepper.sv
// line state, one bresenham step per advance command on an active line, output register
module brl_stepper import brl_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_valid,
    input  cmd_t                    q_cmd,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata,
    output logic                    m_tlast
);

    logic                  active_reg, active_next;
    logic                  major_is_x_reg, major_is_x_next;
    logic                  minor_down_reg, minor_down_next;
    coord_t                cur_x_reg, cur_x_next;
    coord_t                cur_y_reg, cur_y_next;
    coord_t                end_major_reg, end_major_next;
    dec_t                  decision_reg, decision_next;
    dec_t                  inc_straight_reg, inc_straight_next;
    dec_t                  inc_diagonal_reg, inc_diagonal_next;
    logic [COLOR_BITS-1:0] line_color_reg, line_color_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic                  m_tlast_reg, m_tlast_next;
    coord_t                pix_x_reg, pix_x_next;
    coord_t                pix_y_reg, pix_y_next;
    logic [COLOR_BITS-1:0] pix_color_reg, pix_color_next;

    logic   out_free, diag;
    coord_t step_x, step_y, new_major;

    assign out_free = !m_tvalid_reg || m_tready;
    assign q_pop    = q_valid && out_free;
    assign diag     = !decision_reg[DEC_BITS-1];

    always_comb begin
        active_next       = active_reg;
        major_is_x_next   = major_is_x_reg;
        minor_down_next   = minor_down_reg;
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        end_major_next    = end_major_reg;
        decision_next     = decision_reg;
        inc_straight_next = inc_straight_reg;
        inc_diagonal_next = inc_diagonal_reg;
        line_color_next   = line_color_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_tlast_next      = m_tlast_reg;
        pix_x_next        = pix_x_reg;
        pix_y_next        = pix_y_reg;
        pix_color_next    = pix_color_reg;

        step_x    = cur_x_reg;
        step_y    = cur_y_reg;
        new_major = '0;
        if (major_is_x_reg) begin
            step_x    = cur_x_reg + coord_t'(1);
            new_major = step_x;
            if (diag) begin
                step_y = minor_down_reg ? cur_y_reg - coord_t'(1) : cur_y_reg + coord_t'(1);
            end
        end else begin
            step_y    = cur_y_reg + coord_t'(1);
            new_major = step_y;
            if (diag) begin
                step_x = minor_down_reg ? cur_x_reg - coord_t'(1) : cur_x_reg + coord_t'(1);
            end
        end

        if (q_pop) begin
            case (q_cmd.kind)
                OP_START: begin
                    active_next       = !q_cmd.single;
                    major_is_x_next   = q_cmd.major_is_x;
                    minor_down_next   = q_cmd.minor_down;
                    cur_x_next        = q_cmd.start_x;
                    cur_y_next        = q_cmd.start_y;
                    end_major_next    = q_cmd.end_major;
                    decision_next     = q_cmd.decision;
                    inc_straight_next = q_cmd.inc_straight;
                    inc_diagonal_next = q_cmd.inc_diagonal;
                    line_color_next   = q_cmd.color;
                    m_tvalid_next     = 1'b1;
                    m_tlast_next      = q_cmd.single;
                    pix_x_next        = q_cmd.start_x;
                    pix_y_next        = q_cmd.start_y;
                    pix_color_next    = q_cmd.color;
                end
                OP_ADVANCE: begin
                    if (active_reg) begin
                        decision_next  = decision_reg + (diag ? inc_diagonal_reg
                                                              : inc_straight_reg);
                        cur_x_next     = step_x;
                        cur_y_next     = step_y;
                        active_next    = !(new_major >= end_major_reg);
                        m_tvalid_next  = 1'b1;
                        m_tlast_next   = new_major >= end_major_reg;
                        pix_x_next     = step_x;
                        pix_y_next     = step_y;
                        pix_color_next = line_color_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg       <= 1'b0;
            major_is_x_reg   <= 1'b0;
            minor_down_reg   <= 1'b0;
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            end_major_reg    <= '0;
            decision_reg     <= '0;
            inc_straight_reg <= '0;
            inc_diagonal_reg <= '0;
            line_color_reg   <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            active_reg       <= active_next;
            major_is_x_reg   <= major_is_x_next;
            minor_down_reg   <= minor_down_next;
            cur_x_reg        <= cur_x_next;
            cur_y_reg        <= cur_y_next;
            end_major_reg    <= end_major_next;
            decision_reg     <= decision_next;
            inc_straight_reg <= inc_straight_next;
            inc_diagonal_reg <= inc_diagonal_next;
            line_color_reg   <= line_color_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
        m_tlast_reg   <= m_tlast_next;
        pix_x_reg     <= pix_x_next;
        pix_y_reg     <= pix_y_next;
        pix_color_reg <= pix_color_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = M_TDATA_BITS'({pix_color_reg, pix_y_reg, pix_x_reg});

    // a single-point line leaves the stepper idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_cmd.kind == OP_START && q_cmd.single) |=> !active_reg)
        else $error("single point line left stepper active");

    // an advance on an active line always yields a pixel
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_cmd.kind == OP_ADVANCE && active_reg) |=> m_tvalid_reg)
        else $error("advance on active line gave no pixel");

    // an advance while idle leaves the position untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_cmd.kind == OP_ADVANCE && !active_reg)
        |=> ($stable(cur_x_reg) && $stable(cur_y_reg) && !active_reg))
        else $error("idle advance changed line state");

    // the last pixel of a line always clears the active flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && m_tvalid_next && m_tlast_next) |=> !active_reg)
        else $error("line still active after its last pixel");

endmodule

### hw/rtl/bresenham_line_rasterizer_core.sv
// bresenham line rasterizer: setup front, command queue and pixel stepper
// a request is registered in the queue, then its pixel in the output register that drives
// m_tvalid, if the queue is empty and the output register is free
// throughput: one request per cycle unless the queue is full or m_tready stalls the output
// all requests pass a two-entry queue, so setup and stepper stall independently
// reset: synchronous active-low aresetn clears the queue, line state and output valid
// after reset no line is active and advance requests produce no pixel
module bresenham_line_rasterizer_core import brl_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // x_a, y_a, x_b, y_b, color
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    // opcode
    input  logic                    s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // pixel_x, pixel_y, pixel_color
    output logic [M_TDATA_BITS-1:0] m_tdata,
    output logic                    m_tlast
);

    logic q_full, q_push, q_pop, q_valid;
    cmd_t push_cmd, head_cmd;

    brl_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    brl_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    brl_stepper u_stepper (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
